[rtl/core/indexed_list_insert_delete_unit_macros.svh]
// Assertion macros for the indexed list unit.
// Both macros expect clk and rst_n in scope.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ILID_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilid assertion failed");

// Next-cycle implication.
`define ILID_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilid assertion failed");

`else

`define ILID_ASSERT_IMP(lbl, ante, cons)
`define ILID_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/core/ilid_pkg.sv]
package ilid_pkg;

  // default list capacity
  localparam int CAP_DEF = 16;

  // field widths
  localparam int ACT_W   = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 31;
  localparam int LEN_W   = 5;
  localparam int STAT_W  = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS = 2'd0,
    ACT_DEL = 2'd1,
    ACT_CLR = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_RD,
    S_WR,
    S_PUT
  } state_t;

endpackage

[rtl/core/ilid_ram.sv]
module ilid_ram
  import ilid_pkg::*;
#(
  parameter int WIDTH = VAL_W,
  parameter int DEPTH = CAP_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/indexed_list_insert_delete_unit.sv]
// Indexed list unit: holds a left-packed list of up to CAP 31-bit values in
// a single-port-write, registered-read RAM and answers each request with one
// result. Requests: insert at an index (tail moves right), delete at an
// index (tail moves left, removed value returned), clear, and a no-op code.
// Insert into a full list reports status 1 and insert above the length or
// delete at or above the length reports status 2; the list stays unchanged.
// Each element move is a RAM read, then a write back one slot over, so a
// successful insert or delete runs longer the more elements lie past its
// index; the longest are a front insert into a list of CAP-1 and a front
// delete from a full list. Clear, no-op and rejected requests load the
// result register at the accepting edge itself. A finished result sits in
// the output register, and the next request is taken in the cycle after
// that result has been read.
// The RAM needs no clearing after reset: only slots below the count are read.
`include "indexed_list_insert_delete_unit_macros.svh"

module indexed_list_insert_delete_unit
  import ilid_pkg::*;
#(
  parameter int CAP = CAP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request: [1:0] action, [6:2] position, [37:7] item_value, [39:38] zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result: [30:0] removed_value, [35:31] length, [36] is_empty,
  //         [37] is_full, [39:38] status
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;  // slot address
  localparam int CNT_W = $clog2(CAP + 1);              // holds 0..CAP
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // sequencer state
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;      // slot being written
  logic [CNT_W-1:0]       pos_r, pos_nxt;      // request index
  logic [VAL_W-1:0]       val_r, val_nxt;      // value to insert
  logic [VAL_W-1:0]       removed_r, removed_nxt;
  logic                   op_del_r, op_del_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // RAM port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VAL_W-1:0]       ram_wdata, ram_rdata;

  // request fields
  action_t                in_act;
  logic [POS_W-1:0]       in_pos;
  logic [VAL_W-1:0]       in_val;
  logic                   in_fire;

  // shared index step: -1 while shifting right, +1 while shifting left
  logic [CNT_W-1:0]       step_sum;
  logic [CNT_W-1:0]       cnt_dec;

  // result assembly
  logic                   finish;
  status_t                fin_status;
  logic [VAL_W-1:0]       fin_removed;

  assign in_act  = action_t'(in_tdata[ACT_W-1:0]);
  assign in_pos  = in_tdata[ACT_W+POS_W-1:ACT_W];
  assign in_val  = in_tdata[ACT_W+POS_W+VAL_W-1:ACT_W+POS_W];
  assign in_fire = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign step_sum = op_del_r ? (idx_r + CNT_W'(1)) : (idx_r - CNT_W'(1));
  assign cnt_dec  = count_r - CNT_W'(1);

  ilid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAP)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      op_del_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      op_del_r    <= op_del_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    removed_r  <= removed_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    removed_nxt   = removed_r;
    op_del_nxt    = op_del_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ram_we      = 1'b0;
    ram_waddr   = idx_r[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = step_sum[AW-1:0];

    finish      = 1'b0;
    fin_status  = STAT_OK;
    fin_removed = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        ram_raddr = AW'(in_pos);  // delete fetches its victim right away
        if (in_fire) begin
          case (in_act)
            ACT_INS: begin
              if (count_r >= CNT_W'(CAP)) begin
                finish     = 1'b1;
                fin_status = STAT_FULL;
              end else if (CMP_W'(in_pos) > CMP_W'(count_r)) begin
                finish     = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                pos_nxt    = CNT_W'(in_pos);
                val_nxt    = in_val;
                idx_nxt    = count_r;
                op_del_nxt = 1'b0;
                // append needs no shift
                state_nxt  = (CMP_W'(in_pos) == CMP_W'(count_r)) ? S_PUT : S_RD;
              end
            end
            ACT_DEL: begin
              if (CMP_W'(in_pos) >= CMP_W'(count_r)) begin
                finish     = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                pos_nxt    = CNT_W'(in_pos);
                idx_nxt    = CNT_W'(in_pos);
                op_del_nxt = 1'b1;
                state_nxt  = S_TAKE;
              end
            end
            ACT_CLR: begin
              count_nxt = '0;
              finish    = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      S_TAKE: begin
        // victim value is on the RAM output now
        removed_nxt = ram_rdata;
        if (idx_r != cnt_dec) begin
          state_nxt = S_RD;
        end else begin
          count_nxt   = cnt_dec;
          finish      = 1'b1;
          fin_removed = ram_rdata;
          state_nxt   = S_IDLE;
        end
      end

      S_RD: begin
        // neighbor read issued through ram_raddr = step_sum
        state_nxt = S_WR;
      end

      S_WR: begin
        ram_we  = 1'b1;
        idx_nxt = step_sum;
        if (op_del_r) begin
          if (step_sum != cnt_dec) begin
            state_nxt = S_RD;
          end else begin
            count_nxt   = cnt_dec;
            finish      = 1'b1;
            fin_removed = removed_r;
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = (step_sum == pos_r) ? S_PUT : S_RD;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {fin_status,
                       (count_nxt == CNT_W'(CAP)),
                       (count_nxt == '0),
                       LEN_W'(count_nxt),
                       fin_removed};
    end
  end

  // checks
  `ILID_ASSERT_IMP(a_count_cap, 1'b1, count_r <= CNT_W'(CAP))
  `ILID_ASSERT_NXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)
  `ILID_ASSERT_IMP(a_no_run_with_result, state_r != S_IDLE, !out_valid_r)
  `ILID_ASSERT_IMP(a_write_in_seq, ram_we, state_r == S_WR || state_r == S_PUT)

endmodule
